FILE: hdl/sdfw_pkg.sv
// ----------------------------------------------------------------------------
// sdfw_pkg
// Shared types and constants of the signed decimal digit frame writer.
// ----------------------------------------------------------------------------
package sdfw_pkg;

  localparam int MAX_DEVICES = 4;
  localparam int DIGIT_REGS  = 8;
  localparam int NUM_DIGITS  = 10;  // digits of the largest 32-bit magnitude
  localparam int BIN_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] MINUS_CODE = 8'h0A;
  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [3:0] NOOP_ADDR  = 4'h0;
  localparam logic [7:0] NOOP_DATA  = 8'h00;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // One classified item, ready to be written out as frames.
  typedef struct packed {
    logic [1:0]                 tgt;
    logic [2:0]                 start;
    logic [7:0]                 pidx;
    logic [3:0]                 ndig;   // decimal digits, 1..10
    logic [3:0]                 nw;     // register writes that fit, 1..8
    logic                       ovf;
    logic [NUM_DIGITS-1:0][3:0] digits;
  } job_t;

  typedef struct packed {
    logic       item_last;
    logic       overflow;
    logic       frame_last;
    logic [7:0] reg_data;
    logic [3:0] reg_address;
    logic [1:0] chain_slot;
  } out_word_t;

endpackage

FILE: hdl/sdfw_front.sv
// ----------------------------------------------------------------------------
// sdfw_front
// Accepts an item, converts the magnitude to BCD by shift-and-add-3 and
// works out how many register writes fit before queueing the job.
// ----------------------------------------------------------------------------
module sdfw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_target_device,
  input  logic [2:0]          in_start_digit,
  input  logic [31:0]         in_number,
  input  logic [7:0]          in_point_index,
  output logic                q_push,
  output sdfw_pkg::job_t      q_job,
  input  logic                q_full
);

  sdfw_pkg::front_state_t state_r, state_nxt;

  logic [4:0]                           bit_cnt_r, bit_cnt_nxt;
  logic [sdfw_pkg::BIN_W-1:0]           bin_r, bin_nxt;
  logic [sdfw_pkg::NUM_DIGITS-1:0][3:0] bcd_r, bcd_nxt;
  logic [sdfw_pkg::NUM_DIGITS-1:0][3:0] bcd_adj;
  logic [1:0]                           tgt_r;
  logic [2:0]                           start_r;
  logic [7:0]                           pidx_r;
  logic                                 neg_r;

  logic       accept;
  logic [3:0] ndig;
  logic [3:0] total;
  logic [3:0] room;

  assign in_ready = (state_r == sdfw_pkg::F_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdfw_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    unique case (state_r)
      sdfw_pkg::F_IDLE: begin
        if (in_valid) state_nxt = sdfw_pkg::F_CONV;
      end
      sdfw_pkg::F_CONV: begin
        if (bit_cnt_r == 5'(sdfw_pkg::BIN_W - 1)) state_nxt = sdfw_pkg::F_PUSH;
      end
      sdfw_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = sdfw_pkg::F_IDLE;
        end
      end
      default: state_nxt = sdfw_pkg::F_IDLE;
    endcase
  end

  // Digits of five or more get 3 added before the shift so they carry
  // correctly into the next decade.
  always_comb begin
    for (int i = 0; i < sdfw_pkg::NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    if (accept) begin
      bit_cnt_nxt = '0;
      bin_nxt     = in_number[31] ? (~in_number + 32'd1) : in_number;
      bcd_nxt     = '0;
    end else if (state_r == sdfw_pkg::F_CONV) begin
      bit_cnt_nxt = bit_cnt_r + 5'd1;
      bcd_nxt     = {bcd_adj[sdfw_pkg::NUM_DIGITS-1][2:0],
                     bcd_adj[sdfw_pkg::NUM_DIGITS-2:0],
                     bin_r[sdfw_pkg::BIN_W-1]};
      bin_nxt     = {bin_r[sdfw_pkg::BIN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    if (accept) begin
      tgt_r   <= in_target_device;
      start_r <= in_start_digit;
      pidx_r  <= in_point_index;
      neg_r   <= in_number[31];
    end
  end

  // The highest nonzero digit sets the digit count; zero still shows one digit.
  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < sdfw_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) ndig = 4'(i + 1);
    end
  end

  assign total = ndig + {3'd0, neg_r};
  assign room  = 4'(sdfw_pkg::DIGIT_REGS) - {1'b0, start_r};

  always_comb begin
    q_job        = '0;
    q_job.tgt    = tgt_r;
    q_job.start  = start_r;
    q_job.pidx   = pidx_r;
    q_job.ndig   = ndig;
    q_job.nw     = (total < room) ? total : room;
    q_job.ovf    = (total > room);
    q_job.digits = bcd_r;
  end

endmodule

FILE: hdl/sdfw_queue.sv
// ----------------------------------------------------------------------------
// sdfw_queue
// Short job queue between the converter and the frame sequencer.
// ----------------------------------------------------------------------------
module sdfw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdfw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output sdfw_pkg::job_t pop_job,
  output logic           empty
);

  sdfw_pkg::job_t                 entries_r [sdfw_pkg::QUEUE_DEPTH];
  logic [sdfw_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [sdfw_pkg::QPTR_W:0]      count_r;
  logic                           do_push, do_pop;

  assign full    = (count_r == (sdfw_pkg::QPTR_W + 1)'(sdfw_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + {{sdfw_pkg::QPTR_W{1'b0}}, do_push}
                         - {{sdfw_pkg::QPTR_W{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_job;
  end

endmodule

FILE: hdl/sdfw_back.sv
// ----------------------------------------------------------------------------
// sdfw_back
// Walks a queued job write by write and slot by slot, producing one chain
// word per beat.
// ----------------------------------------------------------------------------
module sdfw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           device_count,
  input  logic                 q_empty,
  input  sdfw_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdfw_pkg::out_word_t  out_word
);

  sdfw_pkg::back_state_t state_r, state_nxt;
  sdfw_pkg::job_t        job_r;
  logic [2:0]            k_r, k_nxt;
  logic [1:0]            slot_r, slot_nxt;

  logic [2:0] cnt_eff;
  logic       slot_end, write_end, beat, hit, in_digits, has_point;
  logic [3:0] digit;

  // A count of zero behaves as one device, anything too large as the maximum.
  always_comb begin
    if (device_count == 3'd0) begin
      cnt_eff = 3'd1;
    end else if (device_count > 3'(sdfw_pkg::MAX_DEVICES)) begin
      cnt_eff = 3'(sdfw_pkg::MAX_DEVICES);
    end else begin
      cnt_eff = device_count;
    end
  end

  assign out_valid = (state_r == sdfw_pkg::B_RUN);
  assign beat      = out_valid && out_ready;
  assign slot_end  = ({1'b0, slot_r} == cnt_eff - 3'd1);
  assign write_end = ({1'b0, k_r} == job_r.nw - 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdfw_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    k_nxt     = k_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      sdfw_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          k_nxt     = '0;
          slot_nxt  = '0;
          state_nxt = sdfw_pkg::B_RUN;
        end
      end
      sdfw_pkg::B_RUN: begin
        if (beat) begin
          if (slot_end) begin
            slot_nxt = '0;
            if (write_end) begin
              state_nxt = sdfw_pkg::B_IDLE;
            end else begin
              k_nxt = k_r + 3'd1;
            end
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      default: state_nxt = sdfw_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    slot_r <= slot_nxt;
    if (q_pop) job_r <= q_job;
  end

  // A slot past the end of the chain never matches, so an out-of-range
  // target yields frames of no-ops only.
  assign hit       = (slot_r == job_r.tgt);
  assign in_digits = ({1'b0, k_r} < job_r.ndig);
  assign digit     = job_r.digits[{1'b0, k_r}];
  assign has_point = (job_r.pidx == {5'd0, k_r});

  always_comb begin
    out_word            = '0;
    out_word.chain_slot = slot_r;
    out_word.frame_last = slot_end;
    out_word.item_last  = slot_end && write_end;
    out_word.overflow   = job_r.ovf;
    if (hit) begin
      out_word.reg_address = {1'b0, job_r.start} + 4'd1 + {1'b0, k_r};
      if (in_digits) begin
        out_word.reg_data = {4'd0, digit} | (has_point ? sdfw_pkg::POINT_BIT : 8'h00);
      end else begin
        out_word.reg_data = sdfw_pkg::MINUS_CODE;
      end
    end else begin
      out_word.reg_address = sdfw_pkg::NOOP_ADDR;
      out_word.reg_data    = sdfw_pkg::NOOP_DATA;
    end
  end

endmodule

FILE: hdl/signed_decimal_digit_frame_writer.sv
// ----------------------------------------------------------------------------
// signed_decimal_digit_frame_writer
// Turns a signed value into digit register writes framed for a driver chain.
// ----------------------------------------------------------------------------
// Input beat: a target device, start digit, signed 32-bit number and point
// position. Each decimal digit of the magnitude, least significant first,
// becomes one register write to start_digit + 1 + k, with bit 7 set on the
// pointed digit; a negative value adds a minus code. Writes past digit
// register 8 are dropped and flagged on every beat of the item.
// Every write goes out as one frame of device_count beats (0 counts as 1,
// above 4 as 4), slot 0 first; the target slot carries the write and all
// other slots carry a no-op.
// Flow: the converter accepts an item, runs 32 shift-and-add steps and pushes
// the job. The sequencer sends writes x device_count beats, up to 32, then
// fetches the next job. A two-entry job queue lets the two run concurrently.
// Reset clears both engines and the queue and sets device_count to 1.
// When the receiver stalls, the current beat is held, the queue fills, and
// in_tready then stays low until a queue entry frees up.
// ----------------------------------------------------------------------------
module signed_decimal_digit_frame_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata,     // device_count
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_device[1:0], start_digit[4:2], number[36:5], point_index[44:37]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // chain_slot[1:0], reg_address[5:2], reg_data[13:6], frame_last[14]
  output logic [15:0] out_tdata,
  output logic        out_tlast,     // item_last
  output logic [0:0]  out_tuser      // overflow
);

  logic [2:0]          device_count_r;
  logic                q_push, q_full, q_pop, q_empty;
  sdfw_pkg::job_t      push_job, pop_job;
  sdfw_pkg::out_word_t word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r <= 3'd1;
    end else if (cfg_wen) begin
      device_count_r <= cfg_wdata;
    end
  end

  sdfw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_target_device (in_tdata[1:0]),
    .in_start_digit   (in_tdata[4:2]),
    .in_number        (in_tdata[36:5]),
    .in_point_index   (in_tdata[44:37]),
    .q_push           (q_push),
    .q_job            (push_job),
    .q_full           (q_full)
  );

  sdfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  sdfw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .device_count (device_count_r),
    .q_empty      (q_empty),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_word     (word)
  );

  assign out_tdata = {1'b0, word.frame_last, word.reg_data, word.reg_address, word.chain_slot};
  assign out_tlast = word.item_last;
  assign out_tuser = word.overflow;

endmodule

FILE: hdl/sdfw_checker.sv
// ----------------------------------------------------------------------------
// sdfw_checker
// Port-level checks of the frame writer, bound to the top level.
// ----------------------------------------------------------------------------
module sdfw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wen,
  input logic [2:0]  cfg_wdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // A stalled beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // Nothing is left pending across a reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // The last beat of an item always closes a frame.
  a_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[14])
    else $error("item ended inside a frame");

  // No-op slots carry zero data, and real writes never pass digit register 8.
  a_noop_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:2] != 4'd0 || out_tdata[13:6] == 8'd0)
                   && (out_tdata[5] == 1'b0 || out_tdata[4:2] == 3'd0))
    else $error("bad no-op data or digit address out of range");

endmodule

bind signed_decimal_digit_frame_writer sdfw_checker u_sdfw_checker (.*);

FILE: tb/sv/signed_decimal_digit_frame_writer_tb.sv
// ----------------------------------------------------------------------------
// signed_decimal_digit_frame_writer_tb
// Self-checking bench for the signed decimal digit frame writer.
// ----------------------------------------------------------------------------
// A short stimulus table is run first at the reset device count. Randomized
// phases follow, each under its own device count and one of four mixes of sender
// gaps and receiver stalls. A local predictor computes the chain words of
// every accepted input beat. Each output beat is compared field by field
// with the oldest predicted word.
// ----------------------------------------------------------------------------
module signed_decimal_digit_frame_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  tgt;
    logic [2:0]  start;
    logic [31:0] num;
    logic [7:0]  pt;
    bit          known;
    int          beats;
    bit          ovf;
  } dir_row_t;

  localparam int N_DIR = 16;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 52;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  logic [2:0]          device_count = 3'd1;
  sdfw_pkg::out_word_t chain_words_q[$];
  int                  mismatches = 0;
  int                  sender_idle = 0;
  int                  stall_pct = 0;
  bit                  hold_request = 1'b0;
  int                  hold_left = 0;

  int phase_count[N_PHASES] = '{4, 2, 0, 7, 3, 1, 5, 6};
  int phase_idle[N_PHASES]  = '{0, 64, 0, 29, 0, 29, 64, 0};
  int phase_stall[N_PHASES] = '{0, 0, 64, 29, 0, 29, 0, 64};

  // Rows marked known carry the beat count and overflow flag of the item.
  dir_row_t dir_rows[N_DIR] = '{
    '{2'd0, 3'd0, 32'h0000_0000, 8'hFF, 1'b1, 1, 1'b0},
    '{2'd0, 3'd0, 32'h0000_0000, 8'h00, 1'b1, 1, 1'b0},
    '{2'd0, 3'd0, 32'h0000_0007, 8'h00, 1'b1, 1, 1'b0},
    '{2'd0, 3'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 2, 1'b0},
    '{2'd0, 3'd0, 32'h7FFF_FFFF, 8'h7F, 1'b1, 8, 1'b1},
    '{2'd0, 3'd0, 32'h8000_0000, 8'h80, 1'b1, 8, 1'b1},
    '{2'd0, 3'd7, 32'h0000_0005, 8'hFF, 1'b1, 1, 1'b0},
    '{2'd0, 3'd7, 32'h0000_000C, 8'hFF, 1'b1, 1, 1'b1},
    '{2'd0, 3'd7, 32'hFFFF_FFFD, 8'hFF, 1'b1, 1, 1'b1},
    '{2'd3, 3'd0, 32'h0000_3039, 8'h01, 1'b1, 5, 1'b0},
    '{2'd0, 3'd0, 32'h05F5_E0FF, 8'h07, 1'b1, 8, 1'b0},
    '{2'd0, 3'd0, 32'hFA0A_1F01, 8'hFF, 1'b1, 8, 1'b1},
    '{2'd1, 3'd2, 32'h05E3_0A78, 8'h03, 1'b0, 0, 1'b0},
    '{2'd2, 3'd4, 32'hFFFF_D8F1, 8'h04, 1'b0, 0, 1'b0},
    '{2'd0, 3'd5, 32'hAAAA_AAAA, 8'h55, 1'b0, 0, 1'b0},
    '{2'd0, 3'd3, 32'h5555_5555, 8'hAA, 1'b0, 0, 1'b0}
  };

  signed_decimal_digit_frame_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int chain_length();
    if (device_count == 3'd0) begin
      return 1;
    end
    if (device_count > sdfw_pkg::MAX_DEVICES) begin
      return sdfw_pkg::MAX_DEVICES;
    end
    return int'(device_count);
  endfunction

  // Queues the chain words of one value and returns how many were queued.
  function automatic int predict_frames(logic [1:0] tgt, logic [2:0] start,
                                        logic [31:0] num, logic [7:0] pt);
    logic [7:0]          wr_data[11];
    logic [31:0]         mag;
    logic                neg;
    logic                ovf;
    int                  nwr;
    int                  fits;
    int                  room;
    int                  cnt;
    sdfw_pkg::out_word_t w;
    neg = num[31];
    mag = neg ? 32'd0 - num : num;
    nwr = 0;
    do begin
      wr_data[nwr] = 8'(mag % 10);
      if (nwr == int'($signed(pt))) begin
        wr_data[nwr] = wr_data[nwr] + sdfw_pkg::POINT_BIT;
      end
      nwr++;
      mag = mag / 10;
    end while (mag != 0 && nwr < sdfw_pkg::NUM_DIGITS);
    if (neg) begin
      wr_data[nwr] = sdfw_pkg::MINUS_CODE;
      nwr++;
    end
    // A 3-bit start always leaves room for at least one write.
    room = sdfw_pkg::DIGIT_REGS - int'(start);
    fits = (nwr < room) ? nwr : room;
    ovf = (nwr > fits);
    cnt = chain_length();
    for (int k = 0; k < fits; k++) begin
      for (int s = 0; s < cnt; s++) begin
        w.chain_slot  = 2'(s);
        w.reg_address = (s == int'(tgt)) ? 4'(int'(start) + 1 + k) : sdfw_pkg::NOOP_ADDR;
        w.reg_data    = (s == int'(tgt)) ? wr_data[k] : sdfw_pkg::NOOP_DATA;
        w.frame_last  = (s == cnt - 1);
        w.item_last   = (s == cnt - 1) && (k == fits - 1);
        w.overflow    = ovf;
        chain_words_q.push_back(w);
      end
    end
    return fits * cnt;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_beat();
    sdfw_pkg::out_word_t got;
    sdfw_pkg::out_word_t want;
    got.chain_slot  = out_tdata[1:0];
    got.reg_address = out_tdata[5:2];
    got.reg_data    = out_tdata[13:6];
    got.frame_last  = out_tdata[14];
    got.item_last   = out_tlast;
    got.overflow    = out_tuser[0];
    if (chain_words_q.size() == 0) begin
      $display("%0t unexpected beat: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = chain_words_q.pop_front();
      compare_field("chain_slot", want.chain_slot, got.chain_slot);
      compare_field("reg_address", want.reg_address, got.reg_address);
      compare_field("reg_data", want.reg_data, got.reg_data);
      compare_field("frame_last", want.frame_last, got.frame_last);
      compare_field("item_last", want.item_last, got.item_last);
      compare_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // Receiver: checks accepted beats and decides tready for the next edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_beat();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one input beat and predicts its words once it is accepted.
  task automatic offer_value(input logic [1:0] tgt, input logic [2:0] start,
                             input logic [31:0] num, input logic [7:0] pt,
                             output int beats);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < sender_idle) begin
      gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pt, num, start, tgt};
    do @(posedge clk); while (!in_tready);
    beats = predict_frames(tgt, start, num, pt);
  endtask

  // Stops offering, waits for every predicted word and flags any that never arrive.
  task automatic settle();
    int quiet;
    int left;
    in_tvalid <= 1'b0;
    quiet = 0;
    left = chain_words_q.size();
    while (chain_words_q.size() > 0 && quiet < DRAIN_LIMIT) begin
      @(posedge clk);
      quiet = (chain_words_q.size() < left) ? 0 : quiet + 1;
      left = chain_words_q.size();
    end
    if (chain_words_q.size() > 0) begin
      $display("%0t missing beats: expected %0d more, actual 0", $time,
               chain_words_q.size());
      mismatches++;
      chain_words_q.delete();
    end
    repeat (64) @(posedge clk);
  endtask

  task automatic write_device_count(input logic [2:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    device_count = value;
  endtask

  function automatic logic [31:0] pick_number();
    logic [31:0] m;
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      case (r % 4)
        0: m = 32'h0000_0000;
        1: m = 32'h7FFF_FFFF;
        2: m = 32'h8000_0000;
        default: m = 32'hFFFF_FFFF;
      endcase
    end else begin
      m = $urandom >> $urandom_range(31);
      if ($urandom_range(1) == 1) begin
        m = 32'd0 - m;
      end
    end
    return m;
  endfunction

  initial begin
    int beats;
    logic [1:0] tgt;
    logic [7:0] pt;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run at the reset device count of one.
    for (int i = 0; i < N_DIR; i++) begin
      offer_value(dir_rows[i].tgt, dir_rows[i].start, dir_rows[i].num,
                  dir_rows[i].pt, beats);
      if (dir_rows[i].known && (beats != dir_rows[i].beats ||
          chain_words_q[$].overflow != dir_rows[i].ovf)) begin
        $display("%0t row %0d: expected %0d beats ovf %0b, actual %0d beats ovf %0b",
                 $time, i, dir_rows[i].beats, dir_rows[i].ovf, beats,
                 chain_words_q[$].overflow);
        mismatches++;
      end
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_device_count(3'(phase_count[p]));
      sender_idle = phase_idle[p];
      stall_pct = phase_stall[p];
      // In the first phase the receiver blocks long enough to back up the input.
      if (p == 0) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == PHASE_ITEMS / 2) begin
          settle();
        end
        tgt = ($urandom_range(99) < 80) ? 2'($urandom_range(chain_length() - 1))
                                        : 2'($urandom_range(3));
        pt = ($urandom_range(99) < 70) ? 8'($urandom_range(9))
                                       : 8'($urandom_range(255));
        offer_value(tgt, 3'($urandom_range(7)), pick_number(), pt, beats);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sdfw_pkg.sv
hdl/sdfw_front.sv
hdl/sdfw_queue.sv
hdl/sdfw_back.sv
hdl/signed_decimal_digit_frame_writer.sv
hdl/sdfw_checker.sv
tb/sv/signed_decimal_digit_frame_writer_tb.sv
